[rtl/core/cs2rgb_pkg.sv]
// color space to rgb package: mode codes, fixed-point constants and
// arithmetic helpers used by the pipeline
// no dependencies
`default_nettype none

package cs2rgb_pkg;

  // mode register codes
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_YCC  = 2'd1;
  localparam logic [1:0] MODE_HSV  = 2'd2;

  // how a pixel travels through the pipe
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_YCC    = 2'd1;
  localparam logic [1:0] KIND_HSV    = 2'd2;

  // hsv sectors, named by their (r,g,b) order; five and six share the last order
  localparam logic [2:0] SEC_VTP = 3'd0;
  localparam logic [2:0] SEC_QVP = 3'd1;
  localparam logic [2:0] SEC_PVT = 3'd2;
  localparam logic [2:0] SEC_PQV = 3'd3;
  localparam logic [2:0] SEC_TPV = 3'd4;

  // q16 ycbcr coefficients
  localparam logic signed [17:0] K_CR_R = 18'sd91881;
  localparam logic signed [17:0] K_CB_G = 18'sd22551;
  localparam logic signed [17:0] K_CR_G = 18'sd46799;
  localparam logic signed [17:0] K_CB_B = 18'sd116130;

  // q0.16 one, stored as 2^16
  localparam logic [16:0] Q_ONE = 17'h10000;

  typedef logic [16:0] q16_t;
  typedef logic signed [26:0] yprod_t;
  typedef logic signed [27:0] ysum_t;

  // byte to q0.16: n*65536/255 rounded = n*257 plus one for the upper half
  function automatic q16_t q_frac(input logic [7:0] n);
    logic [16:0] base;
    begin
      base = {1'b0, n, 8'd0} + {9'd0, n};
      q_frac = base + {16'd0, n[7]};
    end
  endfunction

  // q0.16 product, rounded half up
  function automatic q16_t q_mul(input q16_t x, input q16_t y);
    logic [33:0] pr;
    begin
      pr = ({17'd0, x} * {17'd0, y}) + 34'd32768;
      q_mul = pr[32:16];
    end
  endfunction

  // q0.16 to byte: val*255 rounded, saturated
  function automatic logic [7:0] to_byte(input q16_t val);
    logic [24:0] pr;
    begin
      pr = {val, 8'd0} - {8'd0, val} + 25'd32768;
      to_byte = (pr[24:16] > 9'd255) ? 8'd255 : pr[23:16];
    end
  endfunction

  // q16 sum to byte: round half up, clamp to 0..255
  function automatic logic [7:0] ycc_round(input ysum_t sum);
    ysum_t r;
    begin
      r = sum + 28'sd32768;
      if (r < 0) begin
        ycc_round = 8'd0;
      end else if (r[27:16] > 12'd255) begin
        ycc_round = 8'd255;
      end else begin
        ycc_round = r[23:16];
      end
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/cs2rgb_if.sv]
// stream interfaces of the color space converter: pixel in, rgb out
// valid/ready handshake with source and sink modports; no dependencies
`default_nettype none

interface cs2rgb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  modport source(output valid, output chan_a, output chan_b, output chan_c, input ready);
  modport sink(input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

interface cs2rgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[rtl/core/color_space_to_rgb_top.sv]
// color space to rgb converter, four-stage pipeline
// depends on cs2rgb_pkg and the stream interfaces in cs2rgb_if
//
// Usage:
//   pixel : one transaction per pixel, chan_a/b/c = R,G,B or Y,Cb,Cr or H,S,V.
//   rgb   : one transaction per pixel, red/green/blue, in input order.
//   cfg_we/cfg_wdata : writes the 2-bit color mode (0 pass, 1 ycbcr, 2 hsv,
//   3 acts as pass); write it only while no pixel is in flight.
// Timing:
//   a pixel passes s1, s2, s3 and the output register in order; the pipe
//   takes one pixel per clock while rgb is not stalled.
//   The four stages are: sector split and q0.16 conversion, first multiplier
//   rank, second multiplier rank with ycbcr rounding, byte conversion and
//   sector ordering into the output register.
// Reset: rst clears all stage valid bits and sets the mode to pass-through.
// Stall: the whole pipe advances together; while rgb is stalled with a
//   pixel waiting, pixel.ready drops and every stage holds, so nothing is
//   lost or repeated. When the output is empty or taken, a new pixel is
//   accepted in the same cycle.
`default_nettype none

module color_space_to_rgb_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_wdata,
  cs2rgb_pix_if.sink         pixel,
  cs2rgb_rgb_if.source       rgb
);

  logic [1:0] color_mode;
  logic       adv;

  // stage 1 registers
  logic                 s1_valid;
  logic [1:0]           s1_kind;
  logic [7:0]           s1_byp_r, s1_byp_g, s1_byp_b;
  logic [7:0]           s1_y;
  logic signed [8:0]    s1_cb, s1_cr;
  logic [2:0]           s1_hi;
  cs2rgb_pkg::q16_t     s1_f, s1_s, s1_v;

  // stage 2 registers
  logic                 s2_valid;
  logic [1:0]           s2_kind;
  logic [7:0]           s2_byp_r, s2_byp_g, s2_byp_b;
  logic [7:0]           s2_y;
  cs2rgb_pkg::yprod_t   s2_pr, s2_pgb, s2_pgr, s2_pb;
  logic [2:0]           s2_hi;
  cs2rgb_pkg::q16_t     s2_v, s2_p, s2_fs, s2_nfs;

  // stage 3 registers
  logic                 s3_valid;
  logic [1:0]           s3_kind;
  logic [7:0]           s3_r, s3_g, s3_b;
  logic [2:0]           s3_hi;
  cs2rgb_pkg::q16_t     s3_v, s3_p, s3_q, s3_t;

  // output register
  logic                 o_valid;
  logic [7:0]           o_red, o_green, o_blue;

  // stage 1 combinational
  logic [10:0]          m6;
  logic [2:0]           hi_next;
  logic [7:0]           rem_next;
  logic [1:0]           kind_next;

  // stage 3 / 4 combinational
  cs2rgb_pkg::ysum_t    y_ext;
  cs2rgb_pkg::ysum_t    sum_r, sum_g, sum_b;
  logic [7:0]           bv, bp, bq, bt;
  logic [7:0]           h_r, h_g, h_b;

  // whole pipe moves when the output register is free or being taken
  assign adv         = !o_valid || rgb.ready;
  assign pixel.ready = adv;

  assign rgb.valid = o_valid;
  assign rgb.red   = o_red;
  assign rgb.green = o_green;
  assign rgb.blue  = o_blue;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= cs2rgb_pkg::MODE_PASS;
    end else if (cfg_we) begin
      color_mode <= cfg_wdata;
    end
  end

  // hue sector and remainder: 6a split by 255
  always_comb begin
    m6 = {1'b0, pixel.chan_a, 2'b00} + {2'b00, pixel.chan_a, 1'b0};
    if (m6 >= 11'd1530) begin
      hi_next = 3'd6;
    end else if (m6 >= 11'd1275) begin
      hi_next = 3'd5;
    end else if (m6 >= 11'd1020) begin
      hi_next = 3'd4;
    end else if (m6 >= 11'd765) begin
      hi_next = 3'd3;
    end else if (m6 >= 11'd510) begin
      hi_next = 3'd2;
    end else if (m6 >= 11'd255) begin
      hi_next = 3'd1;
    end else begin
      hi_next = 3'd0;
    end
    rem_next = 8'(m6 - 11'(hi_next) * 11'd255);
  end

  // which path this pixel takes
  always_comb begin
    if (color_mode == cs2rgb_pkg::MODE_YCC) begin
      kind_next = cs2rgb_pkg::KIND_YCC;
    end else if (color_mode == cs2rgb_pkg::MODE_HSV && pixel.chan_b != 8'd0) begin
      kind_next = cs2rgb_pkg::KIND_HSV;
    end else begin
      kind_next = cs2rgb_pkg::KIND_DIRECT;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixel.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      o_valid  <= s3_valid;
    end
  end

  // stage 1: capture, chroma offset, q0.16 conversion
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= kind_next;
      if (color_mode == cs2rgb_pkg::MODE_HSV) begin
        // zero saturation gives value on all channels
        s1_byp_r <= pixel.chan_c;
        s1_byp_g <= pixel.chan_c;
      end else begin
        s1_byp_r <= pixel.chan_a;
        s1_byp_g <= pixel.chan_b;
      end
      s1_byp_b <= pixel.chan_c;
      s1_y     <= pixel.chan_a;
      s1_cb    <= $signed({1'b0, pixel.chan_b}) - 9'sd128;
      s1_cr    <= $signed({1'b0, pixel.chan_c}) - 9'sd128;
      s1_hi    <= hi_next;
      s1_f     <= cs2rgb_pkg::q_frac(rem_next);
      s1_s     <= cs2rgb_pkg::q_frac(pixel.chan_b);
      s1_v     <= cs2rgb_pkg::q_frac(pixel.chan_c);
    end
  end

  // stage 2: matrix products, f*s, (1-f)*s and p
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind  <= s1_kind;
      s2_byp_r <= s1_byp_r;
      s2_byp_g <= s1_byp_g;
      s2_byp_b <= s1_byp_b;
      s2_y     <= s1_y;
      s2_pr    <= cs2rgb_pkg::K_CR_R * s1_cr;
      s2_pgb   <= cs2rgb_pkg::K_CB_G * s1_cb;
      s2_pgr   <= cs2rgb_pkg::K_CR_G * s1_cr;
      s2_pb    <= cs2rgb_pkg::K_CB_B * s1_cb;
      s2_hi    <= s1_hi;
      s2_v     <= s1_v;
      s2_p     <= cs2rgb_pkg::q_mul(s1_v, cs2rgb_pkg::Q_ONE - s1_s);
      s2_fs    <= cs2rgb_pkg::q_mul(s1_f, s1_s);
      s2_nfs   <= cs2rgb_pkg::q_mul(cs2rgb_pkg::Q_ONE - s1_f, s1_s);
    end
  end

  // ycbcr sums
  always_comb begin
    y_ext = $signed({4'd0, s2_y, 16'd0});
    sum_r = y_ext + {s2_pr[26], s2_pr};
    sum_g = y_ext - {s2_pgb[26], s2_pgb} - {s2_pgr[26], s2_pgr};
    sum_b = y_ext + {s2_pb[26], s2_pb};
  end

  // stage 3: ycbcr round and clamp, q and t
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind <= s2_kind;
      if (s2_kind == cs2rgb_pkg::KIND_YCC) begin
        s3_r <= cs2rgb_pkg::ycc_round(sum_r);
        s3_g <= cs2rgb_pkg::ycc_round(sum_g);
        s3_b <= cs2rgb_pkg::ycc_round(sum_b);
      end else begin
        s3_r <= s2_byp_r;
        s3_g <= s2_byp_g;
        s3_b <= s2_byp_b;
      end
      s3_hi <= s2_hi;
      s3_v  <= s2_v;
      s3_p  <= s2_p;
      s3_q  <= cs2rgb_pkg::q_mul(s2_v, cs2rgb_pkg::Q_ONE - s2_fs);
      s3_t  <= cs2rgb_pkg::q_mul(s2_v, cs2rgb_pkg::Q_ONE - s2_nfs);
    end
  end

  // hsv bytes and sector ordering
  always_comb begin
    bv = cs2rgb_pkg::to_byte(s3_v);
    bp = cs2rgb_pkg::to_byte(s3_p);
    bq = cs2rgb_pkg::to_byte(s3_q);
    bt = cs2rgb_pkg::to_byte(s3_t);
    case (s3_hi)
      cs2rgb_pkg::SEC_VTP: begin h_r = bv; h_g = bt; h_b = bp; end
      cs2rgb_pkg::SEC_QVP: begin h_r = bq; h_g = bv; h_b = bp; end
      cs2rgb_pkg::SEC_PVT: begin h_r = bp; h_g = bv; h_b = bt; end
      cs2rgb_pkg::SEC_PQV: begin h_r = bp; h_g = bq; h_b = bv; end
      cs2rgb_pkg::SEC_TPV: begin h_r = bt; h_g = bp; h_b = bv; end
      default:             begin h_r = bv; h_g = bp; h_b = bq; end
    endcase
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_kind == cs2rgb_pkg::KIND_HSV) begin
        o_red   <= h_r;
        o_green <= h_g;
        o_blue  <= h_b;
      end else begin
        o_red   <= s3_r;
        o_green <= s3_g;
        o_blue  <= s3_b;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/cs2rgb_checker.sv]
// port-level checks for the color space converter, bound to its top level
// depends on color_space_to_rgb_top and the stream interfaces
`default_nettype none

module cs2rgb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("rgb valid dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("rgb payload changed while stalled");

  // the pipe never refuses a pixel when the output register is free
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("pixel refused with room in the pipe");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("rgb valid right after reset");

endmodule

bind color_space_to_rgb_top cs2rgb_checker u_cs2rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixel.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .out_red   (rgb.red),
  .out_green (rgb.green),
  .out_blue  (rgb.blue)
);

`default_nettype wire
